>>> rtl/mpi_pkg.sv
// Shared types, constants and helpers for the Mandelbrot pixel iterator.
package mpi_pkg;

    // View size and fixed-point format
    localparam int WIDTH     = 64;
    localparam int HEIGHT    = 64;
    localparam int FRAC_BITS = 26;

    // Field widths
    localparam int PIX_W    = 6;
    localparam int CENTER_W = 29;
    localparam int STEP_W   = 27;
    localparam int CNT_W    = 10;
    localparam int RGB_W    = 16;
    localparam int Z_W      = 32;
    localparam int PROD_W   = 2 * Z_W;
    localparam int WIDE_W   = 40;
    localparam int OFFP_W   = PIX_W + STEP_W + 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_PAD_W  = OUT_DATA_W - (2 * PIX_W + CNT_W + RGB_W);

    // Configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Register indexes
    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_STEP     = 2'd2;
    localparam logic [1:0] REG_MAX_ITER = 2'd3;

    // Register reset values
    localparam logic signed [CENTER_W-1:0] CENTER_X_RST = -29'sd46976205;
    localparam logic signed [CENTER_W-1:0] CENTER_Y_RST = '0;
    localparam logic [STEP_W-1:0]          STEP_RST     = 27'd402653;
    localparam logic [CNT_W-1:0]           MAX_ITER_RST = 10'd100;

    // Pixel offsets to the view center and the escape radius squared
    localparam logic signed [PIX_W:0] HALF_X = (PIX_W + 1)'(WIDTH / 2);
    localparam logic signed [PIX_W:0] HALF_Y = (PIX_W + 1)'(HEIGHT / 2);
    localparam logic signed [WIDE_W-1:0] ESC_LIMIT = WIDE_W'(64'd4 << FRAC_BITS);

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_UPD,
        ST_FINISH
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic setup;
        logic mul;
        logic upd;
        logic load_out;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic limit_zero;
        logic escaped;
        logic last_iter;
    } stat_t;

    // Clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [Z_W-1:0] sat_z(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] zmax;
        logic signed [WIDE_W-1:0] zmin;
        zmax = WIDE_W'({1'b0, {(Z_W-1){1'b1}}});
        zmin = -zmax - WIDE_W'(1);
        if (v > zmax) begin
            return {1'b0, {(Z_W-1){1'b1}}};
        end
        else if (v < zmin) begin
            return {1'b1, {(Z_W-1){1'b0}}};
        end
        else begin
            return v[Z_W-1:0];
        end
    endfunction

endpackage

>>> rtl/mpi_regs.sv
// Configuration register file with APB-style access.
module mpi_regs
    import mpi_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [DATA_W-1:0]          pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready,
    output logic signed [CENTER_W-1:0] center_x,
    output logic signed [CENTER_W-1:0] center_y,
    output logic [STEP_W-1:0]          step,
    output logic [CNT_W-1:0]           max_iter
);

    logic signed [CENTER_W-1:0] center_x_reg;
    logic signed [CENTER_W-1:0] center_y_reg;
    logic [STEP_W-1:0]          step_reg;
    logic [CNT_W-1:0]           max_iter_reg;
    logic [1:0]                 index;
    logic                       wr_en;

    assign pready = 1'b1;
    assign index  = paddr[3:2];
    assign wr_en  = psel & penable & pwrite & pready;

    // Write the addressed register on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= CENTER_X_RST;
            center_y_reg <= CENTER_Y_RST;
            step_reg     <= STEP_RST;
            max_iter_reg <= MAX_ITER_RST;
        end
        else if (wr_en)
        begin
            case (index)
                REG_CENTER_X: center_x_reg <= pwdata[CENTER_W-1:0];
                REG_CENTER_Y: center_y_reg <= pwdata[CENTER_W-1:0];
                REG_STEP:     step_reg     <= pwdata[STEP_W-1:0];
                REG_MAX_ITER: max_iter_reg <= pwdata[CNT_W-1:0];
                default:      ;
            endcase
        end
    end

    // Return the addressed register
    always_comb
    begin
        case (index)
            REG_CENTER_X: prdata = DATA_W'(unsigned'(center_x_reg));
            REG_CENTER_Y: prdata = DATA_W'(unsigned'(center_y_reg));
            REG_STEP:     prdata = DATA_W'(step_reg);
            REG_MAX_ITER: prdata = DATA_W'(max_iter_reg);
            default:      prdata = '0;
        endcase
    end

    assign center_x = center_x_reg;
    assign center_y = center_y_reg;
    assign step     = step_reg;
    assign max_iter = max_iter_reg;

endmodule

>>> rtl/mpi_ctrl.sv
// Sequencing state machine and output valid flag for the pixel iterator.
module mpi_ctrl
    import mpi_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    output logic  m_tvalid,
    input  logic  m_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || m_tready;

    // Advance the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = stat.limit_zero ? ST_FINISH : ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (stat.escaped || stat.last_iter)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands and handshake outputs
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_SETUP:  cmd.setup    = 1'b1;
            ST_MUL:    cmd.mul      = 1'b1;
            ST_UPD:    cmd.upd      = !stat.escaped;
            ST_FINISH: cmd.load_out = slot_free;
            default:   ;
        endcase
    end

    // Hold the result valid until the result is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;

`ifndef SYNTH
    a_load_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("result loaded over a pending request");

    a_load_out_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("loaded result not flagged valid");

    a_upd_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD) |-> ($past(state_reg) == ST_MUL))
        else $error("update without a preceding multiply");

    a_setup_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SETUP) |-> $past(s_tvalid && s_tready))
        else $error("setup without an accepted request");
`endif

endmodule

>>> rtl/mpi_dpath.sv
// Fixed-point datapath: c setup, z update, iteration count and color mapping.
module mpi_dpath
    import mpi_pkg::*;
(
    input  logic                       clk,
    input  logic [PIX_W-1:0]           px,
    input  logic [PIX_W-1:0]           py,
    input  logic signed [CENTER_W-1:0] center_x,
    input  logic signed [CENTER_W-1:0] center_y,
    input  logic [STEP_W-1:0]          step,
    input  logic [CNT_W-1:0]           max_iter,
    input  cmd_t                       cmd,
    output stat_t                      stat,
    output logic [OUT_DATA_W-1:0]      out_data
);

    logic [PIX_W-1:0]         px_reg;
    logic [PIX_W-1:0]         py_reg;
    logic signed [Z_W-1:0]    cx_reg;
    logic signed [Z_W-1:0]    cy_reg;
    logic signed [Z_W-1:0]    zx_reg;
    logic signed [Z_W-1:0]    zy_reg;
    logic signed [PROD_W-1:0] pxx_reg;
    logic signed [PROD_W-1:0] pyy_reg;
    logic signed [PROD_W-1:0] pxy_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [OUT_DATA_W-1:0]    out_reg;

    logic signed [PIX_W:0]    off_x;
    logic signed [PIX_W:0]    off_y;
    logic signed [STEP_W:0]   step_s;
    logic signed [OFFP_W-1:0] offp_x;
    logic signed [OFFP_W-1:0] offp_y;
    logic signed [WIDE_W-1:0] cx_wide;
    logic signed [WIDE_W-1:0] cy_wide;
    logic signed [WIDE_W-1:0] zx2;
    logic signed [WIDE_W-1:0] zy2;
    logic signed [WIDE_W-1:0] zxy2;
    logic signed [WIDE_W-1:0] sq_sum;
    logic signed [WIDE_W-1:0] nx_wide;
    logic signed [WIDE_W-1:0] ny_wide;
    logic [7:0]               red8;
    logic [7:0]               green8;
    logic [7:0]               blue8;
    logic [RGB_W-1:0]         rgb;

    // Map the pixel to a point of the complex plane
    assign off_x   = $signed({1'b0, px_reg}) - HALF_X;
    assign off_y   = $signed({1'b0, py_reg}) - HALF_Y;
    assign step_s  = $signed({1'b0, step});
    assign offp_x  = off_x * step_s;
    assign offp_y  = off_y * step_s;
    assign cx_wide = WIDE_W'(offp_x) + WIDE_W'(center_x);
    assign cy_wide = WIDE_W'(offp_y) + WIDE_W'(center_y);

    // Scale the registered products back to the fixed-point format
    assign zx2     = WIDE_W'(pxx_reg >>> FRAC_BITS);
    assign zy2     = WIDE_W'(pyy_reg >>> FRAC_BITS);
    assign zxy2    = WIDE_W'(pxy_reg >>> (FRAC_BITS - 1));
    assign sq_sum  = zx2 + zy2;
    assign nx_wide = zx2 - zy2 + WIDE_W'(cx_reg);
    assign ny_wide = zxy2 + WIDE_W'(cy_reg);

    assign stat.limit_zero = (max_iter == '0);
    assign stat.escaped    = (sq_sum >= ESC_LIMIT);
    assign stat.last_iter  = (cnt_reg == CNT_W'(1));

    // Color channels from the low byte of count times 2, 3 and 5
    assign red8   = {cnt_reg[6:0], 1'b0};
    assign green8 = cnt_reg[7:0] + {cnt_reg[6:0], 1'b0};
    assign blue8  = cnt_reg[7:0] + {cnt_reg[5:0], 2'b00};
    assign rgb    = {red8[7:3], green8[7:2], blue8[7:3]};

    // Capture the pixel of an accepted request
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            px_reg <= px;
            py_reg <= py;
        end
    end

    // Set up c and clear z, then iterate
    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            cx_reg  <= sat_z(cx_wide);
            cy_reg  <= sat_z(cy_wide);
            zx_reg  <= '0;
            zy_reg  <= '0;
            cnt_reg <= max_iter;
        end
        else if (cmd.upd)
        begin
            zx_reg  <= sat_z(nx_wide);
            zy_reg  <= sat_z(ny_wide);
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // Register the three products of z
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            pxx_reg <= zx_reg * zx_reg;
            pyy_reg <= zy_reg * zy_reg;
            pxy_reg <= zx_reg * zy_reg;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg <= {{OUT_PAD_W{1'b0}}, rgb, cnt_reg, py_reg, px_reg};
        end
    end

    assign out_data = out_reg;

endmodule

>>> rtl/mandelbrot_pixel_iterator.sv
// Each step of the loop runs a multiply state and then an update state over one shared
// set of three 32x32 multipliers. A new pixel is accepted only once the previous one has
// left the loop and its result is loaded. A finished result waits in the output register
// while the next pixel runs. Reset (rst_n low, asynchronous) clears the controller and
// valid flag and loads the registers with their reset view; no memory clearing is needed.
module mandelbrot_pixel_iterator
    import mpi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // px[5:0], py[11:6], zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // out_x[5:0], out_y[11:6], iters_left[21:12],
                                             // rgb565[37:22], zero pad
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready
);

    logic signed [CENTER_W-1:0] center_x;
    logic signed [CENTER_W-1:0] center_y;
    logic [STEP_W-1:0]          step;
    logic [CNT_W-1:0]           max_iter;
    cmd_t                       cmd;
    stat_t                      stat;

    mpi_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .center_x (center_x),
        .center_y (center_y),
        .step     (step),
        .max_iter (max_iter)
    );

    mpi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mpi_dpath u_dpath (
        .clk      (clk),
        .px       (s_tdata[PIX_W-1:0]),
        .py       (s_tdata[2*PIX_W-1:PIX_W]),
        .center_x (center_x),
        .center_y (center_y),
        .step     (step),
        .max_iter (max_iter),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (m_tdata)
    );

endmodule
